/* hw/rtl/rvx_pkg.sv */
// Shared types and constants for the register VM execute step.
package rvx_pkg;

  // Default sizes of the register file, the argument file and the request queue.
  localparam int REG_COUNT_DEF   = 16;
  localparam int ARG_COUNT_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Widest reduced index that any legal REG_COUNT or ARG_COUNT needs.
  localparam int IDX_W  = 8;
  localparam int DATA_W = 32;
  localparam int PC_W   = 16;

  // Program counter advances.
  localparam logic [PC_W-1:0] PC_STEP_LONG  = 16'd4;
  localparam logic [PC_W-1:0] PC_STEP_SHORT = 16'd3;

  // Opcodes as they arrive on func.
  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_MULT   = 4'd1,
    OP_DIV    = 4'd2,
    OP_NEG    = 4'd3,
    OP_EQ     = 4'd4,
    OP_LT     = 4'd5,
    OP_LTEQ   = 4'd6,
    OP_JUMP   = 4'd7,
    OP_JUMPIF = 4'd8,
    OP_LOADI  = 4'd9,
    OP_SETARG = 4'd10,
    OP_GETARG = 4'd11,
    OP_END    = 4'd12
  } op_t;

  // Class of a request, decided by the front end.
  typedef enum logic [2:0] {
    K_ALU  = 3'd0,
    K_MUL  = 3'd1,
    K_DIV  = 3'd2,
    K_CTRL = 3'd3,
    K_DATA = 3'd4,
    K_END  = 3'd5,
    K_BAD  = 3'd6
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_END     = 2'd1,
    ST_ILLEGAL = 2'd2,
    ST_DIVZ    = 2'd3
  } status_t;

  // Decoded request as it travels from the front end to the back end.
  typedef struct packed {
    op_t              op;
    kind_t            kind;
    logic [15:0]      opnd_a;
    logic [31:0]      imm;
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] rb;
    logic [IDX_W-1:0] rc;
    logic [IDX_W-1:0] arg_wr;
    logic [IDX_W-1:0] arg_rd;
  } instr_t;

endpackage

/* hw/rtl/rvx_div.sv */
// Iterative signed 32-bit divider, one quotient bit per cycle.
module rvx_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  localparam int STEPS = 32;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      rem;
  logic [31:0]      quo;
  logic [31:0]      dsr;
  logic             neg;
  logic [32:0]      rem_sh;
  logic             fits;

  // Restoring step: shift in the next dividend bit and try to subtract.
  assign rem_sh = {rem, quo[31]};
  assign fits   = rem_sh >= {1'b0, dsr};

  // Sequencing of the iterations.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Magnitudes are taken at start; the sign is applied on the way out.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[31] ? 32'd0 - dividend : dividend;
      dsr <= divisor[31] ? 32'd0 - divisor : divisor;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      rem <= fits ? 32'(rem_sh - {1'b0, dsr}) : rem_sh[31:0];
      quo <= {quo[30:0], fits};
    end
  end

  assign quotient = neg ? 32'd0 - quo : quo;

endmodule

/* hw/rtl/rvx_queue.sv */
// Short request queue between the front end and the back end.
module rvx_queue #(
  parameter int DEPTH = rvx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rvx_pkg::instr_t push_data,
  output logic            full,
  input  logic            pop,
  output rvx_pkg::instr_t head,
  output logic            valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rvx_pkg::instr_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!full || pop))
    else $error("request pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("request popped from an empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue fill level beyond its depth");
`endif

endmodule

/* hw/rtl/rvx_front.sv */
// Front end: accepts requests, reduces the indices and classifies the opcode.
module rvx_front #(
  parameter int REG_COUNT = rvx_pkg::REG_COUNT_DEF,
  parameter int ARG_COUNT = rvx_pkg::ARG_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          func,
  input  logic [15:0]         operand_a,
  input  logic signed [31:0]  operand_b,
  input  logic [15:0]         operand_c,
  output logic                q_push,
  output rvx_pkg::instr_t     q_data,
  input  logic                q_full
);

  localparam bit REG_POW2 = (REG_COUNT & (REG_COUNT - 1)) == 0;
  localparam bit ARG_POW2 = (ARG_COUNT & (ARG_COUNT - 1)) == 0;
  localparam bit FAST     = REG_POW2 && ARG_POW2;

  // Opcode classification.
  function automatic rvx_pkg::kind_t classify(input rvx_pkg::op_t op);
    rvx_pkg::kind_t k;
    unique case (op) inside
      rvx_pkg::OP_ADD, rvx_pkg::OP_NEG, rvx_pkg::OP_EQ, rvx_pkg::OP_LT,
      rvx_pkg::OP_LTEQ:                                k = rvx_pkg::K_ALU;
      rvx_pkg::OP_MULT:                                k = rvx_pkg::K_MUL;
      rvx_pkg::OP_DIV:                                 k = rvx_pkg::K_DIV;
      rvx_pkg::OP_JUMP, rvx_pkg::OP_JUMPIF:            k = rvx_pkg::K_CTRL;
      rvx_pkg::OP_LOADI, rvx_pkg::OP_SETARG,
      rvx_pkg::OP_GETARG:                              k = rvx_pkg::K_DATA;
      rvx_pkg::OP_END:                                 k = rvx_pkg::K_END;
      default:                                         k = rvx_pkg::K_BAD;
    endcase
    return k;
  endfunction

  // Folds one byte into a running remainder modulo n, one bit at a time.
  function automatic logic [rvx_pkg::IDX_W-1:0] mod_byte(
    input logic [rvx_pkg::IDX_W-1:0] r,
    input logic [7:0]                d,
    input logic [rvx_pkg::IDX_W:0]   n
  );
    logic [rvx_pkg::IDX_W:0] t;
    t = {1'b0, r};
    for (int i = 0; i < 8; i++) begin
      t = {t[rvx_pkg::IDX_W-1:0], d[7-i]};
      if (t >= n) begin
        t = t - n;
      end
    end
    return t[rvx_pkg::IDX_W-1:0];
  endfunction

  if (FAST) begin : g_fast
    // Power-of-two sizes: indices are masks, a request passes straight through.
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb begin
      q_data.op     = rvx_pkg::op_t'(func);
      q_data.kind   = classify(rvx_pkg::op_t'(func));
      q_data.opnd_a = operand_a;
      q_data.imm    = $unsigned(operand_b);
      q_data.ra     = rvx_pkg::IDX_W'(operand_a & 16'(REG_COUNT - 1));
      q_data.rb     = rvx_pkg::IDX_W'($unsigned(operand_b) & 32'(REG_COUNT - 1));
      q_data.rc     = rvx_pkg::IDX_W'(operand_c & 16'(REG_COUNT - 1));
      q_data.arg_wr = rvx_pkg::IDX_W'(operand_a & 16'(ARG_COUNT - 1));
      q_data.arg_rd = rvx_pkg::IDX_W'($unsigned(operand_b) & 32'(ARG_COUNT - 1));
    end
  end else begin : g_serial
    // Other sizes: indices are reduced one byte per cycle, high byte first.
    localparam int RED_STEPS = 4;
    localparam int STEP_W    = $clog2(RED_STEPS);
    localparam logic [rvx_pkg::IDX_W:0] REG_N = (rvx_pkg::IDX_W + 1)'(REG_COUNT);
    localparam logic [rvx_pkg::IDX_W:0] ARG_N = (rvx_pkg::IDX_W + 1)'(ARG_COUNT);

    logic                      busy;
    logic                      red_done;
    logic [STEP_W-1:0]         step;
    logic [3:0]                hold_func;
    logic [15:0]               hold_a;
    logic [31:0]               hold_b;
    logic [31:0]               sh_a;
    logic [31:0]               sh_b;
    logic [31:0]               sh_c;
    logic [rvx_pkg::IDX_W-1:0] r_ra;
    logic [rvx_pkg::IDX_W-1:0] r_rb;
    logic [rvx_pkg::IDX_W-1:0] r_rc;
    logic [rvx_pkg::IDX_W-1:0] r_aw;
    logic [rvx_pkg::IDX_W-1:0] r_ar;

    assign in_stall = busy;
    assign q_push   = busy && red_done && !q_full;

    // Control of the reduction and hand-off to the queue.
    always_ff @(posedge clk) begin
      if (rst) begin
        busy     <= 1'b0;
        red_done <= 1'b0;
        step     <= '0;
      end else if (!busy) begin
        if (in_valid) begin
          busy     <= 1'b1;
          red_done <= 1'b0;
          step     <= '0;
        end
      end else if (!red_done) begin
        step <= step + 1'b1;
        if (step == STEP_W'(RED_STEPS - 1)) begin
          red_done <= 1'b1;
        end
      end else if (!q_full) begin
        busy <= 1'b0;
      end
    end

    // Captured request and running remainders.
    always_ff @(posedge clk) begin
      if (!busy && in_valid) begin
        hold_func <= func;
        hold_a    <= operand_a;
        hold_b    <= $unsigned(operand_b);
        sh_a      <= {16'd0, operand_a};
        sh_b      <= $unsigned(operand_b);
        sh_c      <= {16'd0, operand_c};
        r_ra      <= '0;
        r_rb      <= '0;
        r_rc      <= '0;
        r_aw      <= '0;
        r_ar      <= '0;
      end else if (busy && !red_done) begin
        sh_a <= {sh_a[23:0], 8'd0};
        sh_b <= {sh_b[23:0], 8'd0};
        sh_c <= {sh_c[23:0], 8'd0};
        r_ra <= mod_byte(r_ra, sh_a[31:24], REG_N);
        r_rb <= mod_byte(r_rb, sh_b[31:24], REG_N);
        r_rc <= mod_byte(r_rc, sh_c[31:24], REG_N);
        r_aw <= mod_byte(r_aw, sh_a[31:24], ARG_N);
        r_ar <= mod_byte(r_ar, sh_b[31:24], ARG_N);
      end
    end

    always_comb begin
      q_data.op     = rvx_pkg::op_t'(hold_func);
      q_data.kind   = classify(rvx_pkg::op_t'(hold_func));
      q_data.opnd_a = hold_a;
      q_data.imm    = hold_b;
      q_data.ra     = r_ra;
      q_data.rb     = r_rb;
      q_data.rc     = r_rc;
      q_data.arg_wr = r_aw;
      q_data.arg_rd = r_ar;
    end
  end

endmodule

/* hw/rtl/rvx_back.sv */
// Back end: register and argument files, execution, program counter, result register.
module rvx_back #(
  parameter int REG_COUNT = rvx_pkg::REG_COUNT_DEF,
  parameter int ARG_COUNT = rvx_pkg::ARG_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  rvx_pkg::instr_t     q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         next_pc,
  output logic                reg_write,
  output logic [3:0]          write_index,
  output logic signed [31:0]  write_value,
  output logic [1:0]          status
);

  localparam int REG_IW = $clog2(REG_COUNT);
  localparam int ARG_IW = (ARG_COUNT > 1) ? $clog2(ARG_COUNT) : 1;

  typedef enum logic [3:0] {
    B_READ = 4'b0001,
    B_EXEC = 4'b0010,
    B_MUL  = 4'b0100,
    B_DIV  = 4'b1000
  } bstate_t;

  bstate_t                  state;
  bstate_t                  state_next;
  rvx_pkg::instr_t          cur;
  logic [rvx_pkg::PC_W-1:0] pc;

  logic [31:0]          reg_mem [REG_COUNT];
  logic [REG_COUNT-1:0] reg_vld;
  logic [31:0]          arg_mem [ARG_COUNT];
  logic [ARG_COUNT-1:0] arg_vld;

  logic [31:0] vb_mem;
  logic [31:0] vc_mem;
  logic [31:0] av_mem;
  logic        vb_hit;
  logic        vc_hit;
  logic        av_hit;
  logic [31:0] vb;
  logic [31:0] vc;
  logic [31:0] av;
  logic [31:0] prod;

  logic        div_start;
  logic        div_done;
  logic [31:0] div_quo;

  logic                     out_free;
  logic                     commit;
  logic                     reg_we;
  logic                     arg_we;
  logic                     ex_wr;
  logic                     ex_arg_we;
  logic [31:0]              ex_val;
  rvx_pkg::status_t         ex_status;
  logic [rvx_pkg::PC_W-1:0] ex_pc;

  logic [REG_IW-1:0] rb_idx;
  logic [REG_IW-1:0] rc_idx;
  logic [ARG_IW-1:0] ar_idx;
  logic [REG_IW-1:0] ra_idx;
  logic [ARG_IW-1:0] aw_idx;

  assign rb_idx = q_data.rb[REG_IW-1:0];
  assign rc_idx = q_data.rc[REG_IW-1:0];
  assign ar_idx = q_data.arg_rd[ARG_IW-1:0];
  assign ra_idx = cur.ra[REG_IW-1:0];
  assign aw_idx = cur.arg_wr[ARG_IW-1:0];

  // Entries never written since reset read as zero.
  assign vb = vb_hit ? vb_mem : '0;
  assign vc = vc_hit ? vc_mem : '0;
  assign av = av_hit ? av_mem : '0;

  assign out_free = !out_valid || !out_stall;
  assign reg_we   = commit && ex_wr;
  assign arg_we   = commit && ex_arg_we;

  // Divider for the divide opcode.
  rvx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (vb),
    .divisor  (vc),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Result of the current request.
  always_comb begin
    ex_wr     = 1'b0;
    ex_arg_we = 1'b0;
    ex_val    = '0;
    ex_status = rvx_pkg::ST_OK;
    ex_pc     = pc;
    unique case (cur.kind)
      rvx_pkg::K_ALU: begin
        ex_wr = 1'b1;
        ex_pc = pc + rvx_pkg::PC_STEP_LONG;
        case (cur.op)
          rvx_pkg::OP_ADD: ex_val = vb + vc;
          rvx_pkg::OP_NEG: ex_val = 32'd0 - vb;
          rvx_pkg::OP_EQ:  ex_val = {31'd0, vb == vc};
          rvx_pkg::OP_LT:  ex_val = {31'd0, $signed(vb) < $signed(vc)};
          default:         ex_val = {31'd0, !($signed(vc) < $signed(vb))};
        endcase
      end
      rvx_pkg::K_MUL: begin
        ex_wr  = 1'b1;
        ex_val = prod;
        ex_pc  = pc + rvx_pkg::PC_STEP_LONG;
      end
      rvx_pkg::K_DIV: begin
        ex_wr = 1'b1;
        ex_pc = pc + rvx_pkg::PC_STEP_LONG;
        if (vc == '0) begin
          ex_status = rvx_pkg::ST_DIVZ;
        end else begin
          ex_val = div_quo;
        end
      end
      rvx_pkg::K_CTRL: begin
        if (cur.op == rvx_pkg::OP_JUMP || vb != '0) begin
          ex_pc = cur.opnd_a;
        end else begin
          ex_pc = pc + rvx_pkg::PC_STEP_SHORT;
        end
      end
      rvx_pkg::K_DATA: begin
        ex_pc = pc + rvx_pkg::PC_STEP_SHORT;
        case (cur.op)
          rvx_pkg::OP_LOADI: begin
            ex_wr  = 1'b1;
            ex_val = cur.imm;
          end
          rvx_pkg::OP_SETARG: ex_arg_we = 1'b1;
          default: begin
            ex_wr  = 1'b1;
            ex_val = av;
          end
        endcase
      end
      rvx_pkg::K_END: ex_status = rvx_pkg::ST_END;
      default:        ex_status = rvx_pkg::ST_ILLEGAL;
    endcase
  end

  // Sequencer: read operands, execute, wait on multiply or divide, commit.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    commit     = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      B_READ: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = B_EXEC;
        end
      end
      B_EXEC: begin
        if (cur.kind == rvx_pkg::K_MUL) begin
          state_next = B_MUL;
        end else if (cur.kind == rvx_pkg::K_DIV && vc != '0) begin
          div_start  = 1'b1;
          state_next = B_DIV;
        end else if (out_free) begin
          commit     = 1'b1;
          state_next = B_READ;
        end
      end
      B_MUL: begin
        if (out_free) begin
          commit     = 1'b1;
          state_next = B_READ;
        end
      end
      B_DIV: begin
        if (div_done && out_free) begin
          commit     = 1'b1;
          state_next = B_READ;
        end
      end
      default: state_next = B_READ;
    endcase
  end

  // Control state and written-since-reset marks.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_READ;
      pc        <= '0;
      out_valid <= 1'b0;
      reg_vld   <= '0;
      arg_vld   <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        pc        <= ex_pc;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (reg_we) begin
        reg_vld[ra_idx] <= 1'b1;
      end
      if (arg_we) begin
        arg_vld[aw_idx] <= 1'b1;
      end
    end
  end

  // Operand reads, file writes and the product register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur    <= q_data;
      vb_mem <= reg_mem[rb_idx];
      vc_mem <= reg_mem[rc_idx];
      av_mem <= arg_mem[ar_idx];
      vb_hit <= reg_vld[rb_idx];
      vc_hit <= reg_vld[rc_idx];
      av_hit <= arg_vld[ar_idx];
    end
    if (state == B_EXEC) begin
      prod <= vb * vc;
    end
    if (reg_we) begin
      reg_mem[ra_idx] <= ex_val;
    end
    if (arg_we) begin
      arg_mem[aw_idx] <= vb;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (commit) begin
      next_pc     <= ex_pc;
      reg_write   <= ex_wr;
      write_index <= ex_wr ? 4'(cur.ra) : 4'd0;
      write_value <= ex_val;
      status      <= ex_status;
    end
  end

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst) div_start |-> (vc != '0))
    else $error("divider started with a zero divisor");
  a_stop_holds_pc: assert property (@(posedge clk) disable iff (rst)
      (commit && (ex_status == rvx_pkg::ST_END || ex_status == rvx_pkg::ST_ILLEGAL))
      |=> ($stable(pc) && !reg_write))
    else $error("end or illegal request moved the pc or wrote a register");
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
      commit |=> (out_valid && next_pc == pc && state == B_READ))
    else $error("committed request not presented on the result port");
`endif

endmodule

/* hw/rtl/register_vm_execute_step_core.sv */
// Back end: one request at a time, through operand read and execute, plus a wait state
// for multiply or divide (32-step divider); it takes the next request only after commit.
// Front end: with power-of-two file sizes a request enters the queue as it is accepted;
// otherwise the indices are reduced a byte per cycle, and the front end stalls new
// requests until the reduced one is queued. Reset (synchronous rst): pc zero, queue and
// result port empty.
module register_vm_execute_step_core #(
  parameter int REG_COUNT   = rvx_pkg::REG_COUNT_DEF,
  parameter int ARG_COUNT   = rvx_pkg::ARG_COUNT_DEF,
  parameter int QUEUE_DEPTH = rvx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         func,
  input  logic [15:0]        operand_a,
  input  logic signed [31:0] operand_b,
  input  logic [15:0]        operand_c,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        next_pc,
  output logic               reg_write,
  output logic [3:0]         write_index,
  output logic signed [31:0] write_value,
  output logic [1:0]         status
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  rvx_pkg::instr_t q_in;
  rvx_pkg::instr_t q_head;

  // Request intake and classification.
  rvx_front #(
    .REG_COUNT (REG_COUNT),
    .ARG_COUNT (ARG_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .operand_c (operand_c),
    .q_push    (q_push),
    .q_data    (q_in),
    .q_full    (q_full)
  );

  // Decoupling queue.
  rvx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .valid     (q_valid)
  );

  // Execution and state.
  rvx_back #(
    .REG_COUNT (REG_COUNT),
    .ARG_COUNT (ARG_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .next_pc     (next_pc),
    .reg_write   (reg_write),
    .write_index (write_index),
    .write_value (write_value),
    .status      (status)
  );

endmodule

/* verif/tb_register_vm_execute_step_core.sv */
// Self-checking testbench for the register VM execute step core.
`timescale 1ns / 100ps

module tb_register_vm_execute_step_core;
  import rvx_pkg::*;

  localparam int NUM_RANDOM   = 1900;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 150;

  // Opcodes that the block must flag as illegal.
  localparam logic [3:0] ILL_OP_LO = 4'd13;
  localparam logic [3:0] ILL_OP_MID = 4'd14;
  localparam logic [3:0] ILL_OP_HI = 4'd15;

  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] pc;
    logic        wr;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [1:0]  st;
  } step_result_t;

  typedef struct packed {
    logic [3:0]   f;
    logic [15:0]  a;
    logic [31:0]  b;
    logic [15:0]  c;
    logic         typed;
    step_result_t res;
  } instr_vec_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         func;
  logic [15:0]        operand_a;
  logic signed [31:0] operand_b;
  logic [15:0]        operand_c;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        next_pc;
  logic               reg_write;
  logic [3:0]         write_index;
  logic signed [31:0] write_value;
  logic [1:0]         status;

  // Shadow machine state used to predict every result.
  logic [15:0] vm_pc;
  logic [31:0] vm_regs [REG_COUNT_DEF];
  logic [31:0] vm_args [ARG_COUNT_DEF];

  step_result_t pending_results[$];
  instr_vec_t   directed_q[$];
  int           errors;
  int           results_seen;
  int           cycle_count;
  bit           hold_on;
  bit           hold_done;

  register_vm_execute_step_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .operand_c   (operand_c),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .next_pc     (next_pc),
    .reg_write   (reg_write),
    .write_index (write_index),
    .write_value (write_value),
    .status      (status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Executes one instruction against the shadow state and returns its result.
  function automatic step_result_t execute_instr(input logic [3:0] f, input logic [15:0] a,
                                                 input logic [31:0] b, input logic [15:0] c);
    step_result_t r;
    int unsigned  ra;
    int unsigned  rb;
    int unsigned  rc;
    logic [31:0]  vb;
    logic [31:0]  vc;
    ra = a % REG_COUNT_DEF;
    rb = b % REG_COUNT_DEF;
    rc = c % REG_COUNT_DEF;
    vb = vm_regs[rb];
    vc = vm_regs[rc];
    r = '0;
    r.st = ST_OK;
    r.pc = vm_pc;
    case (f)
      OP_ADD: begin
        r.wr = 1'b1; r.val = vb + vc; r.pc = vm_pc + PC_STEP_LONG;
      end
      OP_MULT: begin
        r.wr = 1'b1; r.val = vb * vc; r.pc = vm_pc + PC_STEP_LONG;
      end
      OP_DIV: begin
        r.wr = 1'b1;
        r.pc = vm_pc + PC_STEP_LONG;
        if (vc == 32'd0) begin
          r.st = ST_DIVZ;
        end else if (vb == INT_MIN && vc == ALL_ONES) begin
          // The one quotient that overflows wraps back to the most negative value.
          r.val = INT_MIN;
        end else begin
          r.val = $signed(vb) / $signed(vc);
        end
      end
      OP_NEG: begin
        r.wr = 1'b1; r.val = 32'd0 - vb; r.pc = vm_pc + PC_STEP_LONG;
      end
      OP_EQ: begin
        r.wr = 1'b1; r.val = {31'd0, vb == vc}; r.pc = vm_pc + PC_STEP_LONG;
      end
      OP_LT: begin
        r.wr = 1'b1; r.val = {31'd0, $signed(vb) < $signed(vc)}; r.pc = vm_pc + PC_STEP_LONG;
      end
      OP_LTEQ: begin
        r.wr = 1'b1; r.val = {31'd0, $signed(vb) <= $signed(vc)}; r.pc = vm_pc + PC_STEP_LONG;
      end
      OP_JUMP: begin
        r.pc = a;
      end
      OP_JUMPIF: begin
        r.pc = (vb != 32'd0) ? a : vm_pc + PC_STEP_SHORT;
      end
      OP_LOADI: begin
        r.wr = 1'b1; r.val = b; r.pc = vm_pc + PC_STEP_SHORT;
      end
      OP_SETARG: begin
        vm_args[a % ARG_COUNT_DEF] = vb;
        r.pc = vm_pc + PC_STEP_SHORT;
      end
      OP_GETARG: begin
        r.wr = 1'b1; r.val = vm_args[b % ARG_COUNT_DEF]; r.pc = vm_pc + PC_STEP_SHORT;
      end
      OP_END: begin
        r.st = ST_END;
      end
      default: begin
        r.st = ST_ILLEGAL;
      end
    endcase
    if (r.wr) begin
      vm_regs[ra] = r.val;
      r.idx = ra[3:0];
    end
    vm_pc = r.pc;
    return r;
  endfunction

  function automatic step_result_t mk_res(input logic [15:0] pc, input logic wr,
                                          input logic [3:0] idx, input logic [31:0] val,
                                          input status_t st);
    step_result_t r;
    r.pc = pc; r.wr = wr; r.idx = idx; r.val = val; r.st = st;
    return r;
  endfunction

  task automatic add_vec(input logic [3:0] f, input logic [15:0] a, input logic [31:0] b,
                         input logic [15:0] c, input logic typed, input step_result_t res);
    instr_vec_t v;
    v.f = f; v.a = a; v.b = b; v.c = c; v.typed = typed; v.res = res;
    directed_q.push_back(v);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t: %s mismatch on result %0d: got %h, expected %h",
             $time, what, results_seen, got, want);
  endtask

  // Mostly in-range register indices, now and then a full-width one that must wrap.
  function automatic logic [15:0] pick_reg16();
    if ($urandom_range(0, 99) < 85) return 16'($urandom_range(0, 15));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [31:0] pick_reg32();
    if ($urandom_range(0, 99) < 85) return 32'($urandom_range(0, 15));
    return $urandom();
  endfunction

  // Immediate values weighted toward zero, small numbers and the extremes.
  function automatic logic [31:0] pick_value();
    int n;
    n = $urandom_range(0, 99);
    if (n < 10) return 32'd0;
    if (n < 20) return 32'd1;
    if (n < 28) return ALL_ONES;
    if (n < 34) return INT_MIN;
    if (n < 40) return INT_MAX;
    if (n < 60) return 32'($signed($urandom_range(0, 40)) - 20);
    return $urandom();
  endfunction

  function automatic instr_vec_t gen_random();
    instr_vec_t v;
    int n;
    v = '0;
    v.a = 16'($urandom_range(0, 65535));
    v.b = $urandom();
    v.c = 16'($urandom_range(0, 65535));
    n = $urandom_range(0, 99);
    if (n < 20) begin
      v.f = OP_LOADI; v.a = pick_reg16(); v.b = pick_value();
    end else if (n < 62) begin
      v.f = 4'($urandom_range(OP_ADD, OP_LTEQ));
      v.a = pick_reg16(); v.b = pick_reg32(); v.c = pick_reg16();
    end else if (n < 67) begin
      v.f = OP_JUMP;
    end else if (n < 74) begin
      v.f = OP_JUMPIF; v.b = pick_reg32();
    end else if (n < 80) begin
      v.f = OP_SETARG; v.a = pick_reg16(); v.b = pick_reg32();
    end else if (n < 86) begin
      v.f = OP_GETARG; v.a = pick_reg16(); v.b = pick_reg32();
    end else if (n < 90) begin
      v.f = OP_END;
    end else if (n < 96) begin
      v.f = 4'($urandom_range(ILL_OP_LO, ILL_OP_HI));
    end else begin
      v.f = 4'($urandom_range(0, 15));
    end
    return v;
  endfunction

  // Idle gaps: mostly none, some short, a few long; none while the receiver holds off.
  function automatic int pick_gap();
    int n;
    if (hold_on) return 0;
    n = $urandom_range(0, 99);
    if (n < 55) return 0;
    if (n < 90) return $urandom_range(1, 3);
    if (n < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Offers one request and predicts its result once it is accepted.
  task automatic issue(input instr_vec_t v);
    step_result_t pred;
    @(negedge clk);
    in_valid  <= 1'b1;
    func      <= v.f;
    operand_a <= v.a;
    operand_b <= v.b;
    operand_c <= v.c;
    do @(posedge clk); while (in_stall);
    pred = execute_instr(v.f, v.a, v.b, v.c);
    pending_results.push_back(v.typed ? v.res : pred);
  endtask

  // Leaves the request channel idle with junk on the payload.
  task automatic idle(input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid  <= 1'b0;
      func      <= 4'($urandom_range(0, 15));
      operand_a <= 16'($urandom_range(0, 65535));
      operand_b <= $urandom();
      operand_c <= 16'($urandom_range(0, 65535));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Request stimulus: reset, the directed table, random requests, then drain.
  initial begin : stimulus
    instr_vec_t v;
    in_valid  <= 1'b0;
    func      <= '0;
    operand_a <= '0;
    operand_b <= '0;
    operand_c <= '0;
    rst       <= 1'b1;
    errors = 0;
    vm_pc = '0;
    foreach (vm_regs[i]) vm_regs[i] = '0;
    foreach (vm_args[i]) vm_args[i] = '0;

    // Reset values, divide by zero, illegal opcodes, end and immediate extremes.
    add_vec(OP_ADD, 16'd0, 32'd1, 16'd2, 1'b1, mk_res(16'd4, 1'b1, 4'd0, 32'd0, ST_OK));
    add_vec(OP_DIV, 16'd3, 32'd1, 16'd2, 1'b1, mk_res(16'd8, 1'b1, 4'd3, 32'd0, ST_DIVZ));
    add_vec(ILL_OP_LO, 16'hFFFF, ALL_ONES, 16'hFFFF, 1'b1,
            mk_res(16'd8, 1'b0, 4'd0, 32'd0, ST_ILLEGAL));
    add_vec(ILL_OP_MID, 16'd0, 32'd0, 16'd0, 1'b1, mk_res(16'd8, 1'b0, 4'd0, 32'd0, ST_ILLEGAL));
    add_vec(ILL_OP_HI, 16'h5A5A, INT_MIN, 16'hA5A5, 1'b1,
            mk_res(16'd8, 1'b0, 4'd0, 32'd0, ST_ILLEGAL));
    add_vec(OP_END, 16'hFFFF, ALL_ONES, 16'hFFFF, 1'b1, mk_res(16'd8, 1'b0, 4'd0, 32'd0, ST_END));
    add_vec(OP_LOADI, 16'd1, INT_MAX, 16'd0, 1'b1, mk_res(16'd11, 1'b1, 4'd1, INT_MAX, ST_OK));
    add_vec(OP_LOADI, 16'hFFF2, INT_MIN, 16'd0, 1'b1, mk_res(16'd14, 1'b1, 4'd2, INT_MIN, ST_OK));
    add_vec(OP_LOADI, 16'd3, ALL_ONES, 16'd0, 1'b1, mk_res(16'd17, 1'b1, 4'd3, ALL_ONES, ST_OK));
    // Overflowing arithmetic, comparisons and wrapped register indices.
    add_vec(OP_DIV, 16'd4, 32'd2, 16'd3, 1'b0, '0);
    add_vec(OP_DIV, 16'd5, 32'd1, 16'd3, 1'b0, '0);
    add_vec(OP_MULT, 16'd6, 32'd1, 16'd1, 1'b0, '0);
    add_vec(OP_ADD, 16'd7, 32'd1, 16'd1, 1'b0, '0);
    add_vec(OP_NEG, 16'd8, 32'd2, 16'd0, 1'b0, '0);
    add_vec(OP_EQ, 16'd9, 32'd1, 16'd1, 1'b0, '0);
    add_vec(OP_LT, 16'd10, 32'd2, 16'd1, 1'b0, '0);
    add_vec(OP_LTEQ, 16'd11, 32'd1, 16'hFFF2, 1'b0, '0);
    add_vec(OP_LTEQ, 16'd11, 32'd1, 16'd1, 1'b0, '0);
    // Argument file at the wrapped top index, then the control transfers and a signed divide.
    add_vec(OP_SETARG, 16'hFFFF, 32'hFFFF_FFF1, 16'd0, 1'b0, '0);
    add_vec(OP_GETARG, 16'hFFFF, ALL_ONES, 16'd0, 1'b0, '0);
    add_vec(OP_JUMPIF, 16'hFFFF, 32'd1, 16'd0, 1'b0, '0);
    add_vec(OP_JUMPIF, 16'd0, 32'd0, 16'd0, 1'b0, '0);
    add_vec(OP_JUMP, 16'hFFFF, 32'd0, 16'd0, 1'b0, '0);
    add_vec(OP_LOADI, 16'd0, 32'hFFFF_FFF9, 16'd0, 1'b0, '0);
    add_vec(OP_DIV, 16'd12, 32'd0, 16'd3, 1'b0, '0);
    add_vec(OP_JUMP, 16'd0, 32'd0, 16'd0, 1'b0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_q[i]) begin
      issue(directed_q[i]);
      idle(pick_gap());
    end
    repeat (NUM_RANDOM) begin
      v = gen_random();
      issue(v);
      idle(pick_gap());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result back pressure, with one long hold-off that fills the block.
  initial begin : result_stall
    int n;
    out_stall <= 1'b0;
    hold_on = 1'b0;
    hold_done = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_on = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on = 1'b0;
        hold_done = 1'b1;
      end else begin
        n = $urandom_range(0, 99);
        if (n < 45) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk);
        end else if (n < 55) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(50, 150)) @(negedge clk);
        end else if (n < 85) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 2)) @(negedge clk);
        end else if (n < 97) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(3, 8)) @(negedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(20, 60)) @(negedge clk);
        end
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    step_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {16'd0, next_pc}, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (next_pc !== want.pc) report_mismatch("next_pc", {16'd0, next_pc}, {16'd0, want.pc});
        if (reg_write !== want.wr) report_mismatch("reg_write", {31'd0, reg_write}, {31'd0, want.wr});
        if (write_index !== want.idx)
          report_mismatch("write_index", {28'd0, write_index}, {28'd0, want.idx});
        if (write_value !== want.val) report_mismatch("write_value", write_value, want.val);
        if (status !== want.st) report_mismatch("status", {30'd0, status}, {30'd0, want.st});
      end
      results_seen++;
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    cycle_count = 0;
    results_seen = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
